/* design/rotation_matrix_to_quaternion_unit_macros.svh */
// assertion macros shared by the rotation matrix to quaternion design
// no dependencies
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RMQ_ASSERT(label, clk, rst_n, prop, msg)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/rmq_pkg.sv */
// types and constants for the rotation matrix to quaternion unit
// no dependencies
package rmq_pkg;
  localparam int unsigned MatW = 16;
  localparam int unsigned PosW = 32;
  // radicand: up to 3*2^15 + 2^30, kept in 32 bits
  localparam int unsigned RadW = 32;
  // root operand r << (frac-2) fits 60 bits for frac up to 30
  localparam int unsigned SqW  = 62;
  localparam int unsigned RootW = SqW / 2;
  // numerator magnitude: 2^16 << frac
  localparam int unsigned NumW = 48;
  localparam int unsigned DenW = RootW + 2;

  typedef struct packed {
    logic signed [MatW-1:0] w;
    logic signed [MatW-1:0] x;
    logic signed [MatW-1:0] y;
    logic signed [MatW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } pos_t;

  typedef logic signed [MatW-1:0] mat_t [3][3];

  // saturate a wide signed value to 16 bits
  function automatic logic signed [MatW-1:0] sat16(input logic signed [NumW:0] v);
    logic signed [MatW-1:0] r;
    if (v > (NumW+1)'(signed'(32767))) r = 16'sh7fff;
    else if (v < -(NumW+1)'(signed'(32768))) r = 16'sh8000;
    else r = v[MatW-1:0];
    return r;
  endfunction
endpackage

/* design/rmq_if.sv */
// valid/ready channel carrying a generic payload
// depends on nothing
interface rmq_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rmq_in_t.sv */
// input and output payload records of the quaternion unit
// depends on rmq_pkg
package rmq_io_pkg;
  import rmq_pkg::*;
  typedef struct packed {
    logic signed [MatW-1:0] m_r0c0, m_r0c1, m_r0c2;
    logic signed [MatW-1:0] m_r1c0, m_r1c1, m_r1c2;
    logic signed [MatW-1:0] m_r2c0, m_r2c1, m_r2c2;
    logic signed [PosW-1:0] pos_x, pos_y, pos_z;
  } in_t;
  typedef struct packed {
    logic signed [MatW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [PosW-1:0] out_pos_x, out_pos_y, out_pos_z;
    logic                   degenerate;
  } out_t;
endpackage

/* design/rmq_stage.sv */
// one elastic pipeline stage: a register slot with valid and a stall chain
// depends on nothing
module rmq_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         v_i,
  output logic         rdy_o,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  input  logic         rdy_i,
  output logic [W-1:0] d_o
);
  logic         v_q;
  logic [W-1:0] d_q;
  // advance when empty or downstream takes
  assign rdy_o = !v_q || rdy_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (rdy_o) v_q <= v_i;
  end
  always_ff @(posedge clk_i) begin
    if (rdy_o && v_i) d_q <= d_i;
  end
  assign v_o = v_q;
  assign d_o = d_q;
endmodule

/* design/rmq_sqrt.sv */
// pipelined restoring square root, two result bits per stage
// depends on rmq_pkg
module rmq_sqrt #(
  parameter int unsigned TW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                v_i,
  output logic                rdy_o,
  input  logic [rmq_pkg::SqW-1:0] rad_i,
  input  logic [TW-1:0]       tag_i,
  output logic                v_o,
  input  logic                rdy_i,
  output logic [rmq_pkg::RootW-1:0] root_o,
  output logic [TW-1:0]       tag_o
);
  import rmq_pkg::*;
  localparam int unsigned Steps = RootW;
  localparam int unsigned PerStg = 2;
  localparam int unsigned Stg = (Steps + PerStg - 1) / PerStg;
  localparam int unsigned SW = SqW + SqW + RootW + TW;

  logic [SW-1:0] d [Stg+1];
  logic          v [Stg+1];
  logic          r [Stg+1];

  assign d[0] = {rad_i, {SqW{1'b0}}, {RootW{1'b0}}, tag_i};
  assign v[0] = v_i;
  assign rdy_o = r[0];

  for (genvar s = 0; s < Stg; s++) begin : g_stg
    logic [SW-1:0] nx;
    // digit recurrence: remainder, shifted operand, partial root
    always_comb begin
      logic [SqW-1:0]   op, rem;
      logic [RootW-1:0] rt;
      logic [SqW-1:0]   trial;
      {op, rem, rt} = d[s][SW-1:TW];
      for (int k = 0; k < PerStg; k++) begin
        if (s * PerStg + k < Steps) begin
          rem = {rem[SqW-3:0], op[SqW-1:SqW-2]};
          op  = {op[SqW-3:0], 2'b00};
          trial = {rt[RootW-1:0], 2'b01};
          if (rem >= trial) begin
            rem = rem - trial;
            rt  = {rt[RootW-2:0], 1'b1};
          end else begin
            rt  = {rt[RootW-2:0], 1'b0};
          end
        end
      end
      nx = {op, rem, rt, d[s][TW-1:0]};
    end
    rmq_stage #(.W(SW)) u_st (
      .clk_i, .rst_ni, .v_i(v[s]), .rdy_o(r[s]), .d_i(nx),
      .v_o(v[s+1]), .rdy_i(r[s+1]), .d_o(d[s+1])
    );
  end
  assign r[Stg] = rdy_i;
  assign v_o    = v[Stg];
  assign root_o = d[Stg][TW +: RootW];
  assign tag_o  = d[Stg][TW-1:0];
endmodule

/* design/rmq_div.sv */
// pipelined unsigned divider with round-half-up, four quotient bits per stage
// depends on rmq_pkg
module rmq_div #(
  parameter int unsigned TW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                v_i,
  output logic                rdy_o,
  input  logic [rmq_pkg::NumW-1:0] num_i,
  input  logic [rmq_pkg::DenW-1:0] den_i,
  input  logic [TW-1:0]       tag_i,
  output logic                v_o,
  input  logic                rdy_i,
  output logic [rmq_pkg::NumW-1:0] quo_o,
  output logic [TW-1:0]       tag_o
);
  import rmq_pkg::*;
  localparam int unsigned Nb = NumW + 1;
  localparam int unsigned PerStg = 4;
  localparam int unsigned Stg = (Nb + PerStg - 1) / PerStg;
  localparam int unsigned RemW = DenW + 1;
  localparam int unsigned SW = Nb + RemW + DenW + Nb + TW;

  logic [SW-1:0] d [Stg+1];
  logic          v [Stg+1];
  logic          r [Stg+1];

  // quotient of (num + den/2) / den, equal to (2num + den) / (2den)
  // here we divide a = num + den/2 by den
  logic [Nb-1:0] a0;
  assign a0 = Nb'(num_i) + Nb'(den_i >> 1);
  assign d[0] = {a0, {RemW{1'b0}}, den_i, {Nb{1'b0}}, tag_i};
  assign v[0] = v_i;
  assign rdy_o = r[0];

  for (genvar s = 0; s < Stg; s++) begin : g_stg
    logic [SW-1:0] nx;
    always_comb begin
      logic [Nb-1:0]   op, q;
      logic [RemW-1:0] rem;
      logic [DenW-1:0] dv;
      {op, rem, dv, q} = d[s][SW-1:TW];
      for (int k = 0; k < PerStg; k++) begin
        if (s * PerStg + k < Nb) begin
          rem = {rem[RemW-2:0], op[Nb-1]};
          op  = {op[Nb-2:0], 1'b0};
          if (rem >= RemW'(dv)) begin
            rem = rem - RemW'(dv);
            q   = {q[Nb-2:0], 1'b1};
          end else begin
            q   = {q[Nb-2:0], 1'b0};
          end
        end
      end
      nx = {op, rem, dv, q, d[s][TW-1:0]};
    end
    rmq_stage #(.W(SW)) u_st (
      .clk_i, .rst_ni, .v_i(v[s]), .rdy_o(r[s]), .d_i(nx),
      .v_o(v[s+1]), .rdy_i(r[s+1]), .d_o(d[s+1])
    );
  end
  assign r[Stg] = rdy_i;
  assign v_o    = v[Stg];
  assign quo_o  = d[Stg][TW +: NumW];
  assign tag_o  = d[Stg][TW-1:0];
endmodule

/* design/rotation_matrix_to_quaternion_unit.sv */
// rotation matrix to quaternion unit, Shepperd method, fully pipelined
// depends on rmq_pkg, rmq_io_pkg, rmq_if, rmq_stage, rmq_sqrt, rmq_div and the macro header
//
// usage: one request channel (in_if, sink) carries the nine matrix elements
// in Q2.14 and a Q16.16 position; one result channel (out_if, source)
// returns the quaternion (w, x, y, z) in Q2.14, the position unchanged and
// a degenerate flag. both use valid/ready, a request moves when both high.
// pipeline: one setup stage that also forms the numerators, sixteen root
// stages (two root bits each), thirteen divider stages (four quotient bits
// each, three dividers side by side) and one output stage.
// throughput: one request per cycle while the receiver keeps ready high;
// every stage is an elastic register slot, so the chain is set by the longest stage.
// reset clears all valid bits; payload registers are left as they are.
// when the receiver drops ready the stall travels back stage by stage and
// no request is lost or repeated; ready at the input falls only when every
// slot is full.
`include "rotation_matrix_to_quaternion_unit_macros.svh"
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmq_if.sink   in_if,
  rmq_if.source out_if
);
  import rmq_pkg::*;
  import rmq_io_pkg::*;

  localparam logic signed [RadW-1:0] One = RadW'(1) << FRAC_BITS;

  // tag carried around the root: axis (also marks the branch), degenerate, diffs, position
  typedef struct packed {
    logic [1:0]             axis;   // 3 = w from trace
    logic                   degen;
    logic signed [17:0]     n0, n1, n2;
    pos_t                   pos;
  } tag_t;
  localparam int unsigned TagW = $bits(tag_t);

  // stage 1: trace, axis select, radicand, numerators
  in_t  in_d;
  tag_t t1_d;
  logic [SqW-1:0] rad1_d;
  always_comb begin
    logic signed [MatW-1:0] m [3][3];
    logic signed [RadW-1:0] tr, rr;
    logic [1:0] i;
    in_d = in_if.data;
    i = 2'd0;
    m[0][0] = in_d.m_r0c0; m[0][1] = in_d.m_r0c1; m[0][2] = in_d.m_r0c2;
    m[1][0] = in_d.m_r1c0; m[1][1] = in_d.m_r1c1; m[1][2] = in_d.m_r1c2;
    m[2][0] = in_d.m_r2c0; m[2][1] = in_d.m_r2c1; m[2][2] = in_d.m_r2c2;
    tr = RadW'(m[0][0]) + RadW'(m[1][1]) + RadW'(m[2][2]);
    t1_d.pos = '{in_d.pos_x, in_d.pos_y, in_d.pos_z};
    t1_d.degen = 1'b0;
    if (tr > 0) begin
      t1_d.axis = 2'd3;
      rr = tr + One;
      t1_d.n0 = 18'(m[2][1]) - 18'(m[1][2]);
      t1_d.n1 = 18'(m[0][2]) - 18'(m[2][0]);
      t1_d.n2 = 18'(m[1][0]) - 18'(m[0][1]);
    end else begin
      if (m[1][1] > m[0][0]) i = 2'd1;
      if (m[2][2] > m[i][i]) i = 2'd2;
      t1_d.axis = i;
      // n0 -> w, n1 -> j, n2 -> k
      unique case (i)
        2'd0: begin
          rr = RadW'(m[0][0]) - RadW'(m[1][1]) - RadW'(m[2][2]) + One;
          t1_d.n0 = 18'(m[2][1]) - 18'(m[1][2]);
          t1_d.n1 = 18'(m[1][0]) + 18'(m[0][1]);
          t1_d.n2 = 18'(m[2][0]) + 18'(m[0][2]);
        end
        2'd1: begin
          rr = RadW'(m[1][1]) - RadW'(m[2][2]) - RadW'(m[0][0]) + One;
          t1_d.n0 = 18'(m[0][2]) - 18'(m[2][0]);
          t1_d.n1 = 18'(m[2][1]) + 18'(m[1][2]);
          t1_d.n2 = 18'(m[0][1]) + 18'(m[1][0]);
        end
        default: begin
          rr = RadW'(m[2][2]) - RadW'(m[0][0]) - RadW'(m[1][1]) + One;
          t1_d.n0 = 18'(m[1][0]) - 18'(m[0][1]);
          t1_d.n1 = 18'(m[0][2]) + 18'(m[2][0]);
          t1_d.n2 = 18'(m[1][2]) + 18'(m[2][1]);
        end
      endcase
      if (rr <= 0) t1_d.degen = 1'b1;
    end
    if (t1_d.degen) rad1_d = '0;
    else rad1_d = SqW'(rr) << (FRAC_BITS - 2);
  end

  logic v1, r1;
  logic [SqW+TagW-1:0] s1;
  rmq_stage #(.W(SqW + TagW)) u_s1 (
    .clk_i, .rst_ni, .v_i(in_if.valid), .rdy_o(in_if.ready),
    .d_i({rad1_d, t1_d}), .v_o(v1), .rdy_i(r1), .d_o(s1)
  );

  // root
  logic v2, r2;
  logic [RootW-1:0] root2;
  logic [TagW-1:0]  tag2;
  rmq_sqrt #(.TW(TagW)) u_sqrt (
    .clk_i, .rst_ni, .v_i(v1), .rdy_o(r1), .rad_i(s1[SqW+TagW-1:TagW]),
    .tag_i(s1[TagW-1:0]), .v_o(v2), .rdy_i(r2), .root_o(root2), .tag_o(tag2)
  );

  // magnitudes, signs and divisor for three divisions
  tag_t t2;
  assign t2 = tag_t'(tag2);
  logic [NumW-1:0] a0, a1, a2;
  logic [DenW-1:0] den2;
  always_comb begin
    a0 = NumW'(t2.n0[17] ? -t2.n0 : t2.n0) << FRAC_BITS;
    a1 = NumW'(t2.n1[17] ? -t2.n1 : t2.n1) << FRAC_BITS;
    a2 = NumW'(t2.n2[17] ? -t2.n2 : t2.n2) << FRAC_BITS;
    den2 = {root2, 2'b00};
    if (den2 == '0) den2 = DenW'(1);
  end
  localparam int unsigned T3W = TagW + RootW;
  logic v3a, v3b, v3c, r3a, r3b, r3c;
  logic [NumW-1:0] q0, q1, q2;
  logic [T3W-1:0]  tg3;
  logic [TagW-1:0] unused_b, unused_c;
  logic out_rdy;
  assign r2 = r3a;
  rmq_div #(.TW(T3W)) u_div0 (
    .clk_i, .rst_ni, .v_i(v2), .rdy_o(r3a), .num_i(a0), .den_i(den2),
    .tag_i({root2, tag2}), .v_o(v3a), .rdy_i(out_rdy), .quo_o(q0), .tag_o(tg3)
  );
  rmq_div #(.TW(TagW)) u_div1 (
    .clk_i, .rst_ni, .v_i(v2), .rdy_o(r3b), .num_i(a1), .den_i(den2),
    .tag_i(tag2), .v_o(v3b), .rdy_i(out_rdy), .quo_o(q1), .tag_o(unused_b)
  );
  rmq_div #(.TW(TagW)) u_div2 (
    .clk_i, .rst_ni, .v_i(v2), .rdy_o(r3c), .num_i(a2), .den_i(den2),
    .tag_i(tag2), .v_o(v3c), .rdy_i(out_rdy), .quo_o(q2), .tag_o(unused_c)
  );

  // final assembly into the output register
  tag_t t3;
  logic [RootW-1:0] root3;
  out_t o_d;
  assign {root3, t3} = tg3;
  always_comb begin
    logic signed [MatW-1:0] hs, s0, s1v, s2;
    hs  = sat16((NumW+1)'(root3));
    s0  = sat16(t3.n0[17] ? -$signed({1'b0, q0}) : $signed({1'b0, q0}));
    s1v = sat16(t3.n1[17] ? -$signed({1'b0, q1}) : $signed({1'b0, q1}));
    s2  = sat16(t3.n2[17] ? -$signed({1'b0, q2}) : $signed({1'b0, q2}));
    o_d = '0;
    o_d.out_pos_x = t3.pos.x;
    o_d.out_pos_y = t3.pos.y;
    o_d.out_pos_z = t3.pos.z;
    o_d.degenerate = t3.degen;
    if (!t3.degen) begin
      unique case (t3.axis)
        2'd3: begin o_d.quat_w = hs; o_d.quat_x = s0; o_d.quat_y = s1v; o_d.quat_z = s2; end
        2'd0: begin o_d.quat_x = hs; o_d.quat_w = s0; o_d.quat_y = s1v; o_d.quat_z = s2; end
        2'd1: begin o_d.quat_y = hs; o_d.quat_w = s0; o_d.quat_z = s1v; o_d.quat_x = s2; end
        default: begin
          o_d.quat_z = hs; o_d.quat_w = s0; o_d.quat_x = s1v; o_d.quat_y = s2;
        end
      endcase
    end
  end
  rmq_stage #(.W($bits(out_t))) u_out (
    .clk_i, .rst_ni, .v_i(v3a), .rdy_o(out_rdy), .d_i(o_d),
    .v_o(out_if.valid), .rdy_i(out_if.ready), .d_o(out_if.data)
  );

  // the three dividers move in lockstep
  `RMQ_ASSERT(a_div_lock, clk_i, rst_ni, (v3a == v3b) && (v3b == v3c), "dividers out of step")
  `RMQ_ASSERT(a_rdy_lock, clk_i, rst_ni, (r3a == r3b) && (r3b == r3c), "divider stalls differ")
  `RMQ_ASSERT(a_degen_zero, clk_i, rst_ni, !(out_if.valid && out_if.data.degenerate) || (out_if.data.quat_w == 0 && out_if.data.quat_x == 0), "degenerate result not zeroed")
  `RMQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid, "result dropped under stall")
endmodule

/* tb/sv/tb_rmq_channel_if.sv */
// tb-side note: channels use the design's rmq_if interface directly
// depends on rmq_io_pkg from the design
package tb_rmq_chan_pkg;
  import rmq_io_pkg::*;
  localparam int unsigned PipeDepth = 32;
endpackage

/* tb/sv/tb_top.sv */
// testbench for rotation_matrix_to_quaternion_unit: random and directed matrices,
// a bit-exact quaternion predictor and a field-by-field scoreboard
// depends on rmq_pkg, rmq_io_pkg, rmq_if, tb_rmq_chan_pkg and the design
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;
  import rmq_io_pkg::*;
  import tb_rmq_chan_pkg::*;

  localparam int Frac = 14;
  localparam longint Limit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rmq_if #(.T(in_t))  req_if (clk_i);
  rmq_if #(.T(out_t)) res_if (clk_i);

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(Frac)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(req_if.sink), .out_if(res_if.source)
  );

  in_t    pending_q[$];
  out_t   quat_expect_q[$];
  int     fail_cnt = 0;
  longint cycle_cnt = 0;
  bit     stim_done = 0;
  bit     calm = 0;
  int     send_hold = 0;
  int     recv_hold = 0;

  // floor square root of a 64-bit value
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // n * 2^frac / (4*hr), nearest, ties away from zero
  function automatic longint round_quot(longint n, longint hr);
    longint num;
    longint unsigned d, a, q;
    num = n * (64'sd1 <<< Frac);
    d = hr * 4;
    a = (num < 0) ? -num : num;
    q = (a + d / 2) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // predicted result of one matrix request
  function automatic out_t quat_of(in_t r);
    longint m[3][3];
    longint q[4];
    longint tr, rad, hr, one;
    int i, j, k;
    out_t o;
    m[0][0] = r.m_r0c0; m[0][1] = r.m_r0c1; m[0][2] = r.m_r0c2;
    m[1][0] = r.m_r1c0; m[1][1] = r.m_r1c1; m[1][2] = r.m_r1c2;
    m[2][0] = r.m_r2c0; m[2][1] = r.m_r2c1; m[2][2] = r.m_r2c2;
    q = '{0, 0, 0, 0};
    one = 64'sd1 <<< Frac;
    o = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      hr = floor_sqrt((tr + one) << (Frac - 2));
      q[0] = hr;
      q[1] = round_quot(m[2][1] - m[1][2], hr);
      q[2] = round_quot(m[0][2] - m[2][0], hr);
      q[3] = round_quot(m[1][0] - m[0][1], hr);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + one;
      if (rad <= 0) begin
        o.degenerate = 1'b1;
      end else begin
        hr = floor_sqrt(rad << (Frac - 2));
        q[1 + i] = hr;
        q[0] = round_quot(m[k][j] - m[j][k], hr);
        q[1 + j] = round_quot(m[j][i] + m[i][j], hr);
        q[1 + k] = round_quot(m[k][i] + m[i][k], hr);
      end
    end
    o.quat_w = clamp16(q[0]);
    o.quat_x = clamp16(q[1]);
    o.quat_y = clamp16(q[2]);
    o.quat_z = clamp16(q[3]);
    o.out_pos_x = r.pos_x;
    o.out_pos_y = r.pos_y;
    o.out_pos_z = r.pos_z;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    fail_cnt++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
  endtask

  function automatic logic signed [15:0] rnd_elem();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s == 0) return 16'sh8000;
    if (s == 1) return 16'sh7fff;
    if (s < 6) return 16'(int'($urandom_range(0, 32768)) - 16384);
    return 16'($urandom);
  endfunction

  // near-rotation: random axis permutation with signs plus small noise
  function automatic in_t rnd_rot();
    in_t r;
    logic signed [15:0] e[9];
    int p[3];
    int s, n;
    p = '{0, 1, 2};
    p.shuffle();
    for (int a = 0; a < 9; a++) e[a] = 16'(int'($urandom_range(0, 600)) - 300);
    for (int a = 0; a < 3; a++) begin
      s = $urandom_range(0, 1) ? 16384 : -16384;
      n = int'($urandom_range(0, 8000));
      e[a * 3 + p[a]] = 16'(s > 0 ? s - n : s + n);
    end
    r.m_r0c0 = e[0]; r.m_r0c1 = e[1]; r.m_r0c2 = e[2];
    r.m_r1c0 = e[3]; r.m_r1c1 = e[4]; r.m_r1c2 = e[5];
    r.m_r2c0 = e[6]; r.m_r2c1 = e[7]; r.m_r2c2 = e[8];
    r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
    return r;
  endfunction

  function automatic in_t diag_req(int a, int b, int c, int off);
    in_t r;
    r = '0;
    r.m_r0c0 = 16'(a); r.m_r1c1 = 16'(b); r.m_r2c2 = 16'(c);
    r.m_r0c1 = 16'(off); r.m_r1c2 = 16'(-off); r.m_r2c0 = 16'(off);
    return r;
  endfunction

  // stimulus
  initial begin
    in_t r;
    pending_q.push_back(diag_req(16384, 16384, 16384, 0));
    pending_q.push_back(diag_req(1, 0, 0, 0));
    pending_q.push_back(diag_req(32767, 32767, 32767, 32767));
    pending_q.push_back(diag_req(16384, -16384, -16384, 100));
    pending_q.push_back(diag_req(-16384, 16384, -16384, -100));
    pending_q.push_back(diag_req(-16384, -16384, 16384, 200));
    pending_q.push_back(diag_req(0, 0, 0, 0));
    pending_q.push_back(diag_req(-32768, -32768, -32768, -32768));
    pending_q.push_back(diag_req(-100, -100, -100, 5));
    pending_q.push_back(diag_req(-16384, 16384, 16384, 0));
    pending_q.push_back(diag_req(-32768, 32767, 0, 0));
    pending_q.push_back(diag_req(1, 1, -2, 9));
    r = '1;
    pending_q.push_back(r);
    r = '0;
    r.m_r0c0 = 16'sh8000; r.m_r1c1 = 16'sh7fff; r.m_r2c2 = 16'sh7fff;
    r.m_r0c1 = 16'sh8000; r.m_r1c0 = 16'sh7fff; r.m_r2c1 = 16'sh7fff;
    r.m_r1c2 = 16'sh8000;
    r.pos_x = 32'h8000_0000; r.pos_y = 32'h7fff_ffff; r.pos_z = 32'hffff_ffff;
    pending_q.push_back(r);
    for (int n = 0; n < 600; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        r = rnd_rot();
      end else begin
        r.m_r0c0 = rnd_elem(); r.m_r0c1 = rnd_elem(); r.m_r0c2 = rnd_elem();
        r.m_r1c0 = rnd_elem(); r.m_r1c1 = rnd_elem(); r.m_r1c2 = rnd_elem();
        r.m_r2c0 = rnd_elem(); r.m_r2c1 = rnd_elem(); r.m_r2c2 = rnd_elem();
        r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
      end
      pending_q.push_back(r);
    end
    stim_done = 1;
  end

  // reset
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    calm <= stim_done && (pending_q.size() < 120);
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      res_if.ready <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        quat_expect_q.push_back(quat_of(req_if.data));
        void'(pending_q.pop_front());
      end
      // request side: hold, burst idle, or present head
      if (req_if.valid && !req_if.ready) begin
        req_if.valid <= 1'b1;
      end else if (send_hold > 0) begin
        send_hold <= send_hold - 1;
        req_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_hold <= $urandom_range(0, 15);
        req_if.valid <= 1'b0;
      end else begin
        if (pending_q.size() > 0) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_q[0];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      // result side stall bursts
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_hold <= $urandom_range(0, 15);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t g, w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      g = res_if.data;
      if (quat_expect_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = quat_expect_q.pop_front();
        if (g.quat_w !== w.quat_w) report("quat_w", g.quat_w, w.quat_w);
        if (g.quat_x !== w.quat_x) report("quat_x", g.quat_x, w.quat_x);
        if (g.quat_y !== w.quat_y) report("quat_y", g.quat_y, w.quat_y);
        if (g.quat_z !== w.quat_z) report("quat_z", g.quat_z, w.quat_z);
        if (g.out_pos_x !== w.out_pos_x) report("out_pos_x", g.out_pos_x, w.out_pos_x);
        if (g.out_pos_y !== w.out_pos_y) report("out_pos_y", g.out_pos_y, w.out_pos_y);
        if (g.out_pos_z !== w.out_pos_z) report("out_pos_z", g.out_pos_z, w.out_pos_z);
        if (g.degenerate !== w.degenerate) report("degenerate", g.degenerate, w.degenerate);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while ((pending_q.size() != 0 || quat_expect_q.size() != 0 || req_if.valid)
           && cycle_cnt < Limit)
      @(posedge clk_i);
    if (cycle_cnt >= Limit) begin
      $display("** rotation_matrix_to_quaternion_unit: FAILED **");
    end else begin
      repeat (2 * PipeDepth) @(posedge clk_i);
      if (fail_cnt == 0) begin
        $display("** rotation_matrix_to_quaternion_unit: PASSED **");
      end else begin
        $display("** rotation_matrix_to_quaternion_unit: FAILED **");
      end
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/rmq_pkg.sv
design/rmq_if.sv
design/rmq_in_t.sv
design/rmq_stage.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion_unit.sv
tb/sv/tb_rmq_channel_if.sv
tb/sv/tb_top.sv
